>>> hw/rtl/lvd_pkg.sv
package lvd_pkg;

  // Item kinds; the codes match the mode field of an input word.
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_QUERY   = 2'd3
  } op_e_t;

  localparam int CHAR_W = 8;
  localparam int FIELD_W = 7;

  // Control part of a token moving down the chain.
  typedef struct packed {
    logic              vld;
    op_e_t             op;
    logic [CHAR_W-1:0] ch;
    logic              err;
  } tok_ctl_t;

endpackage

>>> hw/rtl/lvd_if.sv
interface lvd_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [lvd_pkg::CHAR_W-1:0] character;

  modport source (output valid, output mode, output character, input ready);
  modport sink (input valid, input mode, input character, output ready);
endinterface

interface lvd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lvd_pkg::FIELD_W-1:0] distance;
  logic [lvd_pkg::FIELD_W-1:0] pattern_length;
  logic [lvd_pkg::FIELD_W-1:0] text_length;
  logic                        error;

  modport source (output valid, output distance, output pattern_length,
                  output text_length, output error, input ready);
  modport sink (input valid, input distance, input pattern_length,
                input text_length, input error, output ready);
endinterface

>>> hw/rtl/lvd_cell.sv
module lvd_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  lvd_pkg::tok_ctl_t in_ctl,
  input  logic [CW-1:0]     in_left,
  input  logic [CW-1:0]     in_diag,
  input  logic [CW-1:0]     in_plen,
  input  logic [CW-1:0]     in_tlen,
  output lvd_pkg::tok_ctl_t out_ctl,
  output logic [CW-1:0]     out_left,
  output logic [CW-1:0]     out_diag,
  output logic [CW-1:0]     out_plen,
  output logic [CW-1:0]     out_tlen
);

  logic                       act_r, act_nxt;
  logic [CW-1:0]              cost_r, cost_nxt;
  logic [lvd_pkg::CHAR_W-1:0] pat_r, pat_nxt;
  lvd_pkg::tok_ctl_t          ctl_r, ctl_nxt;
  logic [CW-1:0]              left_r, left_nxt;
  logic [CW-1:0]              diag_r, diag_nxt;
  logic [CW-1:0]              plen_r, tlen_r;

  logic [CW:0] up1, lf1, sub, best;

  // Recurrence: min(above + 1, left + 1, diagonal + mismatch)
  always_comb begin
    up1  = {1'b0, cost_r} + 1'b1;
    lf1  = {1'b0, in_left} + 1'b1;
    sub  = {1'b0, in_diag} + {{CW{1'b0}}, (pat_r != in_ctl.ch)};
    best = (up1 < lf1) ? up1 : lf1;
    if (sub < best) begin
      best = sub;
    end
  end

  always_comb begin
    act_nxt  = act_r;
    cost_nxt = cost_r;
    pat_nxt  = pat_r;
    left_nxt = in_left;
    diag_nxt = in_diag;
    if (in_ctl.vld) begin
      case (in_ctl.op)
        lvd_pkg::OP_CLEAR: begin
          act_nxt  = 1'b0;
          cost_nxt = CW'(IDX + 1);
        end
        lvd_pkg::OP_PATTERN: begin
          if (in_left == CW'(IDX)) begin
            pat_nxt = in_ctl.ch;
            act_nxt = 1'b1;
          end
        end
        lvd_pkg::OP_TEXT: begin
          if (act_r) begin
            cost_nxt = best[CW-1:0];
            left_nxt = best[CW-1:0];
            diag_nxt = cost_r;
          end
        end
        lvd_pkg::OP_QUERY: begin
          if (act_r) begin
            left_nxt = cost_r;
            cost_nxt = CW'(IDX + 1);
          end
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
    ctl_nxt = in_ctl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      cost_r <= CW'(IDX + 1);
      ctl_r  <= '0;
    end else if (adv) begin
      act_r  <= act_nxt;
      cost_r <= cost_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pat_r  <= pat_nxt;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      plen_r <= in_plen;
      tlen_r <= in_tlen;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_left = left_r;
  assign out_diag = diag_r;
  assign out_plen = plen_r;
  assign out_tlen = tlen_r;

  // An unused cell keeps its initial column value.
  a_idle_cost: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> cost_r == CW'(IDX + 1))
    else $error("idle cell lost its column value");

  // A cell only comes into use through a pattern token.
  a_act_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(act_r) |-> $past(in_ctl.vld && in_ctl.op == lvd_pkg::OP_PATTERN && adv))
    else $error("cell became active without a pattern token");

endmodule

>>> hw/rtl/lvd_head.sv
module lvd_head #(
  parameter int MAX_LEN = 64,
  parameter int CW      = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       acc,
  input  logic [1:0]                 mode,
  input  logic [lvd_pkg::CHAR_W-1:0] character,
  output lvd_pkg::tok_ctl_t          out_ctl,
  output logic [CW-1:0]              out_left,
  output logic [CW-1:0]              out_diag,
  output logic [CW-1:0]              out_plen,
  output logic [CW-1:0]              out_tlen
);

  logic [CW-1:0]     pc_r, pc_nxt;
  logic [CW-1:0]     tc_r, tc_nxt;
  logic              err_r, err_nxt;
  lvd_pkg::tok_ctl_t ctl_r, ctl_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [CW-1:0]     diag_r, diag_nxt;
  logic [CW-1:0]     plen_r, tlen_r;

  always_comb begin
    pc_nxt       = pc_r;
    tc_nxt       = tc_r;
    err_nxt      = err_r;
    ctl_nxt.vld  = 1'b0;
    ctl_nxt.op   = lvd_pkg::op_e_t'(mode);
    ctl_nxt.ch   = character;
    ctl_nxt.err  = err_r;
    left_nxt     = tc_r;
    diag_nxt     = tc_r;
    if (acc) begin
      case (lvd_pkg::op_e_t'(mode))
        lvd_pkg::OP_CLEAR: begin
          pc_nxt      = '0;
          tc_nxt      = '0;
          err_nxt     = 1'b0;
          ctl_nxt.vld = 1'b1;
        end
        lvd_pkg::OP_PATTERN: begin
          // drop bytes after text has started or past the end of the store
          if (tc_r != '0 || pc_r == CW'(MAX_LEN)) begin
            err_nxt = 1'b1;
          end else begin
            ctl_nxt.vld = 1'b1;
            left_nxt    = pc_r;
            pc_nxt      = pc_r + 1'b1;
          end
        end
        lvd_pkg::OP_TEXT: begin
          if (tc_r == CW'(MAX_LEN)) begin
            err_nxt = 1'b1;
          end else begin
            ctl_nxt.vld = 1'b1;
            left_nxt    = tc_r + 1'b1;
            tc_nxt      = tc_r + 1'b1;
          end
        end
        lvd_pkg::OP_QUERY: begin
          ctl_nxt.vld = 1'b1;
          tc_nxt      = '0;
          err_nxt     = 1'b0;
        end
        default: begin
          ctl_nxt.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      tc_r  <= '0;
      err_r <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      pc_r  <= pc_nxt;
      tc_r  <= tc_nxt;
      err_r <= err_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      plen_r <= pc_r;
      tlen_r <= tc_r;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_left = left_r;
  assign out_diag = diag_r;
  assign out_plen = plen_r;
  assign out_tlen = tlen_r;

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= CW'(MAX_LEN))
    else $error("pattern count beyond store depth");

  a_tc_range: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r <= CW'(MAX_LEN))
    else $error("text count beyond limit");

endmodule

>>> hw/rtl/levenshtein_distance_engine.sv
// Channel | Dir | Word fields                                        | Handshake
// in_ch   | in  | mode[1:0], character[7:0]                          | valid/ready
// out_ch  | out | distance[6:0], pattern_length[6:0],                | valid/ready
//         |     | text_length[6:0], error                            |
// Every input word is registered in the head; a new word may follow in the next cycle unless a result is stalled.
// A query result passes the head register, every cell of the chain and the result register.
// Reset (rst_n low, synchronous) empties the chain and gives an empty pattern and text.
// A result waiting with out_ch.ready low freezes the whole chain and drops in_ch.ready.
// A clear or query token resets each cell's column value as it passes that cell.
module levenshtein_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lvd_in_if.sink    in_ch,
  lvd_out_if.source out_ch
);

  // Cost and count width: values run from 0 up to MAX_LEN inclusive.
  localparam int CW = $clog2(MAX_LEN + 1);

  logic adv;
  logic acc;

  // Token lanes; lane 0 leaves the head, lane k leaves cell k-1.
  lvd_pkg::tok_ctl_t ctl_lane  [0:MAX_LEN];
  logic [CW-1:0]     left_lane [0:MAX_LEN];
  logic [CW-1:0]     diag_lane [0:MAX_LEN];
  logic [CW-1:0]     plen_lane [0:MAX_LEN];
  logic [CW-1:0]     tlen_lane [0:MAX_LEN];

  logic                        out_valid_r, out_valid_nxt;
  logic [lvd_pkg::FIELD_W-1:0] dist_r, plen_r, tlen_r;
  logic                        err_r;
  logic                        tail_query;

  // Advance the whole chain unless a finished result is still waiting.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // Head: keeps the counts and the error flag, drops bad bytes, issues tokens.
  lvd_head #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW)
  ) u_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .acc       (acc),
    .mode      (in_ch.mode),
    .character (in_ch.character),
    .out_ctl   (ctl_lane[0]),
    .out_left  (left_lane[0]),
    .out_diag  (diag_lane[0]),
    .out_plen  (plen_lane[0]),
    .out_tlen  (tlen_lane[0])
  );

  // One cell per pattern position; a text token sweeps the row one cell a cycle while the chain
  // advances, so successive text bytes follow each other down the chain as a skewed wave.
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    lvd_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_ctl   (ctl_lane[k]),
      .in_left  (left_lane[k]),
      .in_diag  (diag_lane[k]),
      .in_plen  (plen_lane[k]),
      .in_tlen  (tlen_lane[k]),
      .out_ctl  (ctl_lane[k+1]),
      .out_left (left_lane[k+1]),
      .out_diag (diag_lane[k+1]),
      .out_plen (plen_lane[k+1]),
      .out_tlen (tlen_lane[k+1])
    );
  end

  // A query token leaves the chain carrying the cost of the last used cell.
  assign tail_query = ctl_lane[MAX_LEN].vld && (ctl_lane[MAX_LEN].op == lvd_pkg::OP_QUERY);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = tail_query;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word until it is taken.
  always_ff @(posedge clk) begin
    if (adv && tail_query) begin
      dist_r <= lvd_pkg::FIELD_W'(left_lane[MAX_LEN]);
      plen_r <= lvd_pkg::FIELD_W'(plen_lane[MAX_LEN]);
      tlen_r <= lvd_pkg::FIELD_W'(tlen_lane[MAX_LEN]);
      err_r  <= ctl_lane[MAX_LEN].err;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distance       = dist_r;
  assign out_ch.pattern_length = plen_r;
  assign out_ch.text_length    = tlen_r;
  assign out_ch.error          = err_r;

  // A stalled result must not be overwritten by a query leaving the chain.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(dist_r) && $stable(tlen_r))
    else $error("waiting result word overwritten");

endmodule
